// ===== hw/rtl/erd_pkg.sv =====
`timescale 1ns / 1ps
// erd_pkg: shared types and constants of the e-paper refresh decider.
// Depends on nothing; used by every module under hw/rtl.
package erd_pkg;

    localparam int HASH_W    = 32;
    localparam int MINUTES_W = 32;
    localparam int PCOUNT_W  = 16;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_W     = 32;
    localparam int S_DATA_W  = 64;
    localparam int M_DATA_W  = 8;

    // Register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_PARTIAL_LIMIT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_MINUTE_LIMIT  = 1'b1;

    localparam logic [PCOUNT_W-1:0]  PARTIAL_LIMIT_RST = 16'd10;
    localparam logic [MINUTES_W-1:0] MINUTE_LIMIT_RST  = 32'd60;

    typedef enum logic [1:0] {
        KIND_SKIP    = 2'd0,
        KIND_PARTIAL = 2'd1,
        KIND_FULL    = 2'd2
    } t_kind;

    // One refresh request as held in the input register
    typedef struct packed {
        logic                 force_in;
        logic [MINUTES_W-1:0] minutes_in;
        logic [HASH_W-1:0]    hash_in;
    } t_req;

    // Limits from the configuration registers
    typedef struct packed {
        logic [PCOUNT_W-1:0]  partial_limit;
        logic [MINUTES_W-1:0] minute_limit;
    } t_limits;

endpackage

// ===== hw/rtl/erd_in_reg.sv =====
`timescale 1ns / 1ps
// erd_in_reg: input register of the refresh decider.
// Depends on erd_pkg (t_req).
module erd_in_reg (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  erd_pkg::t_req i_req,
    output logic          o_valid,
    input  logic          i_pop,
    output erd_pkg::t_req o_req
);

    logic          r_valid;
    logic          n_valid;
    erd_pkg::t_req r_req;
    logic          take;

    // Accept when empty or when the held request leaves this cycle
    assign o_ready = !r_valid || i_pop;
    assign take    = i_valid && o_ready;

    always_comb begin
        n_valid = r_valid;
        if (take) begin
            n_valid = 1'b1;
        end else if (i_pop) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_req <= i_req;
        end
    end

    assign o_valid = r_valid;
    assign o_req   = r_req;

endmodule

// ===== hw/rtl/erd_core.sv =====
`timescale 1ns / 1ps
// erd_core: panel state, refresh decision and result register.
// Depends on erd_pkg (t_req, t_limits, t_kind).
module erd_core (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_pop,
    input  erd_pkg::t_req    i_req,
    input  erd_pkg::t_limits i_limits,
    output logic             o_valid,
    input  logic             i_ready,
    output erd_pkg::t_kind   o_kind
);

    logic                          r_drawn;
    logic [erd_pkg::HASH_W-1:0]    r_shown_hash;
    logic [erd_pkg::PCOUNT_W-1:0]  r_pcount;
    logic [erd_pkg::MINUTES_W-1:0] r_minutes;
    logic                          r_out_valid;
    erd_pkg::t_kind                r_kind;

    logic                          n_drawn;
    logic [erd_pkg::HASH_W-1:0]    n_shown_hash;
    logic [erd_pkg::PCOUNT_W-1:0]  n_pcount;
    logic [erd_pkg::MINUTES_W-1:0] n_minutes;
    logic                          n_out_valid;
    erd_pkg::t_kind                n_kind;

    logic [erd_pkg::MINUTES_W:0]   min_sum;
    logic [erd_pkg::MINUTES_W-1:0] min_sat;
    logic                          full;
    logic                          load;

    // Result slot free, or its result taken this cycle
    assign load  = i_valid && (!r_out_valid || i_ready);
    assign o_pop = load;

    assign min_sum = {1'b0, r_minutes} + {1'b0, i_req.minutes_in};
    assign min_sat = min_sum[erd_pkg::MINUTES_W] ? '1 : min_sum[erd_pkg::MINUTES_W-1:0];

    assign full = !r_drawn || i_req.force_in ||
                  (r_pcount >= i_limits.partial_limit) ||
                  (min_sat >= i_limits.minute_limit);

    always_comb begin
        n_drawn      = r_drawn;
        n_shown_hash = r_shown_hash;
        n_pcount     = r_pcount;
        n_minutes    = r_minutes;
        n_kind       = r_kind;
        n_out_valid  = r_out_valid && !i_ready;
        if (load) begin
            n_out_valid = 1'b1;
            n_minutes   = min_sat;
            if (full) begin
                n_drawn      = 1'b1;
                n_shown_hash = i_req.hash_in;
                n_pcount     = '0;
                n_minutes    = '0;
                n_kind       = erd_pkg::KIND_FULL;
            end else if (i_req.hash_in == r_shown_hash) begin
                n_kind = erd_pkg::KIND_SKIP;
            end else begin
                n_shown_hash = i_req.hash_in;
                // hold at the top instead of wrapping
                if (r_pcount != '1) begin
                    n_pcount = r_pcount + 1'b1;
                end
                n_kind = erd_pkg::KIND_PARTIAL;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_drawn      <= 1'b0;
            r_shown_hash <= '0;
            r_pcount     <= '0;
            r_minutes    <= '0;
            r_out_valid  <= 1'b0;
            r_kind       <= erd_pkg::KIND_SKIP;
        end else begin
            r_drawn      <= n_drawn;
            r_shown_hash <= n_shown_hash;
            r_pcount     <= n_pcount;
            r_minutes    <= n_minutes;
            r_out_valid  <= n_out_valid;
            r_kind       <= n_kind;
        end
    end

    assign o_valid = r_out_valid;
    assign o_kind  = r_kind;

`ifndef SYNTHESIS
    a_full_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (load && full) |=> (r_pcount == '0 && r_minutes == '0 && r_drawn))
        else $error("full refresh left a counter uncleared");
    a_skip_keeps_hash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (load && !full && i_req.hash_in == r_shown_hash) |=> $stable(r_shown_hash))
        else $error("skip changed the shown hash");
    a_drawn_sticks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_drawn |=> r_drawn)
        else $error("panel drawn flag fell");
    a_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_ready) |=> (r_out_valid && $stable(r_kind)))
        else $error("stalled result lost or changed");
`endif

endmodule

// ===== hw/rtl/epaper_refresh_decider.sv =====
`timescale 1ns / 1ps
// epaper_refresh_decider: top level of the e-paper refresh decider.
// Depends on erd_pkg, erd_in_reg and erd_core.
//
// For each refresh request (content hash, minutes elapsed, force flag) the
// block returns one decision: skip, partial or full refresh. Minutes add into
// a counter that saturates at all ones; a full refresh is ordered when the
// panel was never drawn, when forced, when the partial count has reached
// partial_limit or when the updated minute count has reached minute_limit,
// and it clears both counters. Otherwise a changed hash gives a partial
// refresh (partial count saturates at 65535) and an unchanged one a skip.
// Each request passes through the input register, then through the decision
// logic into the result register. One request is accepted every cycle while
// results are taken; the state update is done in the decision logic itself,
// so consecutive requests never wait on each other. Write the limits only
// while no request is in flight.
module epaper_refresh_decider (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // request stream
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // [31:0] hash_in, [63:32] minutes_in
    input  logic [erd_pkg::S_DATA_W-1:0]  s_axis_tdata,
    // [0] force_in
    input  logic                          s_axis_tuser,
    // decision stream
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // [1:0] refresh_kind, [7:2] zero
    output logic [erd_pkg::M_DATA_W-1:0]  m_axis_tdata,
    // configuration writes
    input  logic                          i_cfg_we,
    input  logic [erd_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [erd_pkg::CFG_W-1:0]     i_cfg_data
);

    erd_pkg::t_limits r_limits;
    erd_pkg::t_req    s_req;
    erd_pkg::t_req    held_req;
    erd_pkg::t_kind   kind;
    logic             held_valid;
    logic             pop;

    // Limit registers: plain writes, no read-back
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limits.partial_limit <= erd_pkg::PARTIAL_LIMIT_RST;
            r_limits.minute_limit  <= erd_pkg::MINUTE_LIMIT_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                erd_pkg::CFG_PARTIAL_LIMIT: begin
                    r_limits.partial_limit <= i_cfg_data[erd_pkg::PCOUNT_W-1:0];
                end
                erd_pkg::CFG_MINUTE_LIMIT: begin
                    r_limits.minute_limit <= i_cfg_data[erd_pkg::MINUTES_W-1:0];
                end
                default: begin
                    r_limits <= r_limits;
                end
            endcase
        end
    end

    // Unpack the request transaction
    assign s_req.hash_in    = s_axis_tdata[erd_pkg::HASH_W-1:0];
    assign s_req.minutes_in = s_axis_tdata[erd_pkg::S_DATA_W-1:erd_pkg::HASH_W];
    assign s_req.force_in   = s_axis_tuser;

    erd_in_reg u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_req   (s_req),
        .o_valid (held_valid),
        .i_pop   (pop),
        .o_req   (held_req)
    );

    erd_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (held_valid),
        .o_pop    (pop),
        .i_req    (held_req),
        .i_limits (r_limits),
        .o_valid  (m_axis_tvalid),
        .i_ready  (m_axis_tready),
        .o_kind   (kind)
    );

    // Pad the decision to a whole byte
    assign m_axis_tdata = {{(erd_pkg::M_DATA_W-2){1'b0}}, kind};

endmodule
